@@ hdl/hidsn_pkg.sv @@
// Shared types and constants for the image header dimension sniffer.
// Used by every module of the block; depends on nothing.
package hidsn_pkg;

  // One input beat: file byte plus end-of-file mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    logic        found;
    logic [31:0] width;
    logic [31:0] height;
  } result_t;

  // Lead bytes that pick the format
  localparam logic [7:0] LEAD_PNG  = 8'h89;
  localparam logic [7:0] LEAD_GIF  = 8'h47;
  localparam logic [7:0] LEAD_RIFF = 8'h52;
  localparam logic [7:0] MARK_FF   = 8'hFF;

  // Signatures, first byte in the top bits
  localparam logic [63:0] SIG_PNG   = 64'h89504E470D0A1A0A;
  localparam logic [47:0] SIG_GIF87 = 48'h474946383761;
  localparam logic [47:0] SIG_GIF89 = 48'h474946383961;
  localparam logic [31:0] SIG_RIFF  = 32'h52494646;
  localparam logic [31:0] SIG_WEBP  = 32'h57454250;
  localparam logic [31:0] TAG_VP8   = 32'h56503820;
  localparam logic [31:0] TAG_VP8L  = 32'h5650384C;
  localparam logic [31:0] TAG_VP8X  = 32'h56503858;

  // JPEG marker codes
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_TEM    = 8'h01;
  localparam logic [7:0] MARK_RST0   = 8'hD0;
  localparam logic [7:0] MARK_RST7   = 8'hD7;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hCF;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  // Byte positions where a format is checked or decided
  localparam logic [5:0] POS_JPEG_SOI  = 6'd1;
  localparam logic [5:0] POS_GIF_DONE  = 6'd9;
  localparam logic [5:0] POS_JPEG_WALK = 6'd11;
  localparam logic [5:0] POS_WEBP_TAG  = 6'd15;
  localparam logic [5:0] POS_PNG_DONE  = 6'd23;
  localparam logic [5:0] POS_WEBP_DONE = 6'd29;
  localparam logic [5:0] POS_MAX       = 6'd63;

  localparam int HDR_DEPTH = 30;
  localparam int WIN_DEPTH = 9;

endpackage

@@ hdl/image_header_dimension_sniffer_unit.sv @@
// Image header dimension sniffer, top level: PNG, GIF, WebP and JPEG headers.
// A result is loaded into the output register when the parser takes its deciding beat.
// Throughput: one byte beat per cycle; the parser step sits between the input
// register and the output register, and stalls only while a result waits.
// Reset: rst_n synchronous, active low; clears position, mode and handshake state.
// Depends on hidsn_pkg, hidsn_in_reg, hidsn_parse, hidsn_out_reg.
module image_header_dimension_sniffer_unit
  import hidsn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] width, [63:32] height
  output logic        out_tuser   // found
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    take;
  logic    emit;
  logic    out_busy;
  result_t step_result;
  result_t out_result;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  hidsn_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_tvalid),
    .in_ready_o (in_tready),
    .in_item_i  (in_item),
    .take_i     (take),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  hidsn_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .out_busy_i   (out_busy),
    .take_o       (take),
    .emit_o       (emit),
    .result_o     (step_result)
  );

  hidsn_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (emit),
    .result_i    (step_result),
    .out_ready_i (out_tready),
    .out_valid_o (out_tvalid),
    .busy_o      (out_busy),
    .result_o    (out_result)
  );

  assign out_tdata = {out_result.height, out_result.width};
  assign out_tuser = out_result.found;

endmodule

@@ hdl/hidsn_in_reg.sv @@
// Input register stage: holds one accepted byte beat until the parser takes it.
// Depends on hidsn_pkg.
module hidsn_in_reg
  import hidsn_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready_o = !valid_r || take_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid_i && in_ready_o) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid_i && in_ready_o) begin
      item_r <= in_item_i;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

@@ hdl/hidsn_parse.sv @@
// Header parser: byte position, parse mode, header store, JPEG marker window
// and the per-byte decision logic. Depends on hidsn_pkg.
module hidsn_parse
  import hidsn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid_i,
  input  item_t   item_i,
  input  logic    out_busy_i,
  output logic    take_o,
  output logic    emit_o,
  output result_t result_o
);

  typedef enum logic [1:0] {MODE_HDR, MODE_JPEG, MODE_DONE} mode_t;

  mode_t       mode_r, mode_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [16:0] skip_r, skip_nxt;
  logic [7:0]  hs_r  [HDR_DEPTH];
  logic [7:0]  win_r [WIN_DEPTH];

  logic [7:0]  b;
  logic [7:0]  hv [HDR_DEPTH];
  logic [7:0]  jw [WIN_DEPTH+1];
  logic [7:0]  h0;
  logic [7:0]  mk;
  logic [15:0] seg_len;
  logic [31:0] tag;
  logic        webp_ok;
  logic        emit_any;
  result_t     res;

  assign b = item_i.data_byte;

  // header view with the current byte forwarded at its own position
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      hv[i] = (pos_r == 6'(i)) ? b : hs_r[i];
    end
    for (int k = 0; k < WIN_DEPTH; k++) begin
      jw[k] = win_r[k];
    end
    jw[WIN_DEPTH] = b;
  end

  assign h0      = hv[0];
  assign mk      = jw[1];
  assign seg_len = {jw[2], jw[3]};
  assign tag     = {hv[12], hv[13], hv[14], hv[15]};
  assign webp_ok = ({hv[0], hv[1], hv[2], hv[3]} == SIG_RIFF) &&
                   ({hv[8], hv[9], hv[10], hv[11]} == SIG_WEBP) &&
                   (tag == TAG_VP8 || tag == TAG_VP8L || tag == TAG_VP8X);

  // per-byte decision
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    skip_nxt = skip_r;
    emit_any = 1'b0;
    res      = '0;

    if (mode_r == MODE_HDR) begin
      if (pos_r == 6'd0) begin
        if (!(h0 inside {LEAD_PNG, LEAD_GIF, LEAD_RIFF, MARK_FF})) begin
          emit_any = 1'b1;
        end
      end else if (pos_r == POS_JPEG_SOI && h0 == MARK_FF) begin
        if (hv[1] != MARK_SOI) begin
          emit_any = 1'b1;
        end else begin
          mode_nxt = MODE_JPEG;
          skip_nxt = '0;
        end
      end else if (pos_r == POS_GIF_DONE && h0 == LEAD_GIF) begin
        emit_any = 1'b1;
        if ({hv[0], hv[1], hv[2], hv[3], hv[4], hv[5]} == SIG_GIF87 ||
            {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5]} == SIG_GIF89) begin
          res.found  = 1'b1;
          res.width  = 32'({hv[7], hv[6]});
          res.height = 32'({hv[9], hv[8]});
        end
      end else if (pos_r == POS_WEBP_TAG && h0 == LEAD_RIFF) begin
        emit_any = !webp_ok;
      end else if (pos_r == POS_PNG_DONE && h0 == LEAD_PNG) begin
        emit_any = 1'b1;
        if ({hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]} == SIG_PNG) begin
          res.found  = 1'b1;
          res.width  = {hv[16], hv[17], hv[18], hv[19]};
          res.height = {hv[20], hv[21], hv[22], hv[23]};
        end
      end else if (pos_r == POS_WEBP_DONE && h0 == LEAD_RIFF) begin
        emit_any = 1'b1;
        if (tag == TAG_VP8) begin
          res.found  = 1'b1;
          res.width  = 32'({hv[27][5:0], hv[26]});
          res.height = 32'({hv[29][5:0], hv[28]});
        end else if (tag == TAG_VP8L) begin
          // 14-bit fields packed in a little-endian word at byte 21
          res.found  = 1'b1;
          res.width  = 32'({hv[22][5:0], hv[21]}) + 32'd1;
          res.height = 32'({hv[24][3:0], hv[23], hv[22][7:6]}) + 32'd1;
        end else if (tag == TAG_VP8X) begin
          res.found  = 1'b1;
          res.width  = 32'({hv[26], hv[25], hv[24]}) + 32'd1;
          res.height = 32'({hv[29], hv[28], hv[27]}) + 32'd1;
        end
      end
    end else if (mode_r == MODE_JPEG && pos_r >= POS_JPEG_WALK) begin
      // marker walk on the window, oldest byte first
      if (skip_r != '0) begin
        skip_nxt = skip_r - 17'd1;
      end else if (jw[0] == MARK_FF && mk != MARK_FF) begin
        if (mk inside {MARK_SOI, MARK_TEM, [MARK_RST0:MARK_RST7]}) begin
          skip_nxt = 17'd1;
        end else if (mk inside {[MARK_SOF_LO:MARK_SOF_HI]} && mk != MARK_DHT &&
                     mk != MARK_JPG && mk != MARK_DAC) begin
          emit_any   = 1'b1;
          res.found  = 1'b1;
          res.width  = 32'({jw[7], jw[8]});
          res.height = 32'({jw[5], jw[6]});
        end else if (seg_len < 16'd2) begin
          emit_any = 1'b1;
        end else begin
          skip_nxt = 17'(seg_len) + 17'd1;
        end
      end
    end

    if (emit_any) begin
      mode_nxt = MODE_DONE;
    end

    // end of file: undecided files report zeros, then start over
    if (item_i.last_byte) begin
      if (!emit_any && mode_r != MODE_DONE) begin
        emit_any = 1'b1;
        res      = '0;
      end
      mode_nxt = MODE_HDR;
      pos_nxt  = '0;
      skip_nxt = '0;
    end else if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 6'd1;
    end

    if (!item_valid_i) begin
      emit_any = 1'b0;
    end
  end

  assign take_o   = item_valid_i && !(emit_any && out_busy_i);
  assign emit_o   = take_o && emit_any;
  assign result_o = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HDR;
      pos_r  <= '0;
      skip_r <= '0;
    end else if (take_o) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      skip_r <= skip_nxt;
    end
  end

  // header store and marker window, no reset
  always_ff @(posedge clk) begin
    if (take_o) begin
      if (mode_r != MODE_DONE && pos_r < 6'(HDR_DEPTH)) begin
        hs_r[pos_r[4:0]] <= b;
      end
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WIN_DEPTH-1] <= b;
    end
  end

`ifndef SYNTHESIS
  a_no_second_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_DONE) |-> !emit_any)
    else $error("second result for one file");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (take_o && item_i.last_byte) |=> (pos_r == '0 && mode_r == MODE_HDR && skip_r == '0))
    else $error("file state not cleared after last byte");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_o && !result_o.found) |-> (result_o.width == '0 && result_o.height == '0))
    else $error("failed result carries nonzero dimensions");

  a_skip_in_jpeg: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != '0) |-> (mode_r == MODE_JPEG))
    else $error("segment skip pending outside JPEG walk");
`endif

endmodule

@@ hdl/hidsn_out_reg.sv @@
// Output register: holds one result beat until the downstream side takes it.
// Depends on hidsn_pkg.
module hidsn_out_reg
  import hidsn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    busy_o,
  output result_t result_o
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign busy_o = valid_r && !out_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      result_r <= result_i;
    end
  end

  assign out_valid_o = valid_r;
  assign result_o    = result_r;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for image_header_dimension_sniffer_unit.
// Streams PNG, GIF, WebP and JPEG files (sound, broken and cut short) through the byte port
// and checks every result beat against a local dimension predictor or a typed answer. Depends on hidsn_pkg.
module tb;
  import hidsn_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NDIR        = 23;
  localparam int WIN_BYTES   = 10;

  // Header content used by the file builders
  localparam logic [31:0] CHUNK_IHDR = 32'h49484452;
  localparam logic [31:0] IHDR_LEN   = 32'd13;
  localparam logic [7:0]  MARK_APP0  = 8'hE0;
  localparam logic [7:0]  MARK_COM   = 8'hFE;
  localparam logic [15:0] SOF_LEN    = 16'd17;

  // File shapes the builder knows
  typedef enum logic [4:0] {
    F_RAW, F_PNG, F_PNG_BADSIG, F_GIF87, F_GIF89, F_GIF_BAD,
    F_VP8, F_VP8L, F_VP8X, F_WEBP_BADTAG, F_RIFF_NOWEBP,
    F_JPEG, F_JPEG_ALL, F_JPEG_BADLEN, F_JPEG_BADSOI, F_JPEG_TRUNC, F_JPEG_LONG
  } file_kind_e;

  // Directed row: file shape, dimensions, trailing bytes, cut length, typed answer
  typedef struct packed {
    file_kind_e  kind;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] extra;
    logic [15:0] cut;
    logic        fixed;
    result_t     want;
  } file_row_t;

  typedef enum logic [1:0] {SNIFF_HDR, SNIFF_JPEG, SNIFF_DONE} sniff_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  int send_idle = 6;
  int recv_idle = 45;
  int errors    = 0;
  int byte_cnt  = 0;
  int file_cnt  = 0;
  int dims_seen = 0;
  int cycle_cnt = 0;

  logic [7:0] file_q[$];
  result_t    dims_q[$];
  logic       cur_fixed;
  result_t    cur_want;
  file_row_t  dir_tab [NDIR];

  // Predictor state, one file at a time
  logic [7:0]  sn_hdr [HDR_DEPTH];
  logic [7:0]  sn_win [WIN_BYTES];
  logic [5:0]  sn_pos;
  sniff_mode_e sn_mode;
  logic [16:0] sn_skip;
  logic        sn_done;

  image_header_dimension_sniffer_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Run-away guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      dims_seen++;
      if (dims_q.size() == 0) begin
        $display("%0t: unexpected result beat found=%0b w=%h h=%h", $time, out_tuser,
                 out_tdata[31:0], out_tdata[63:32]);
        errors++;
      end else begin
        if (out_tuser !== dims_q[0].found) begin
          $display("%0t: found exp %0b got %0b", $time, dims_q[0].found, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== dims_q[0].width) begin
          $display("%0t: width exp %h got %h", $time, dims_q[0].width, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== dims_q[0].height) begin
          $display("%0t: height exp %h got %h", $time, dims_q[0].height, out_tdata[63:32]);
          errors++;
        end
        void'(dims_q.pop_front());
      end
    end
  end

  // Per-file predictor state back to its start values
  function automatic void sniff_clear();
    int k;
    for (k = 0; k < HDR_DEPTH; k++) sn_hdr[k] = 8'h00;
    for (k = 0; k < WIN_BYTES; k++) sn_win[k] = 8'h00;
    sn_pos  = '0;
    sn_mode = SNIFF_HDR;
    sn_skip = '0;
    sn_done = 1'b0;
  endfunction

  function automatic logic [31:0] hdr_be32(int at);
    return {sn_hdr[at], sn_hdr[at+1], sn_hdr[at+2], sn_hdr[at+3]};
  endfunction

  // Dimension predictor: one accepted byte in, at most one result out
  task automatic sniff_byte(input logic [7:0] b, input logic last, output bit got,
                            output result_t r);
    logic [5:0]  p;
    logic [7:0]  h0;
    logic [7:0]  m;
    logic [15:0] len;
    logic [31:0] v;
    logic [31:0] tag;
    bit          dec;
    logic        df;
    logic [31:0] dw;
    logic [31:0] dh;
    int          k;
    p   = sn_pos;
    got = 1'b0;
    r   = '0;
    dec = 1'b0;
    df  = 1'b0;
    dw  = '0;
    dh  = '0;
    for (k = 0; k < WIN_BYTES - 1; k++) sn_win[k] = sn_win[k+1];
    sn_win[WIN_BYTES-1] = b;

    if (!sn_done) begin
      if (p < HDR_DEPTH) sn_hdr[p] = b;
      h0  = sn_hdr[0];
      tag = hdr_be32(12);
      if (sn_mode == SNIFF_HDR) begin
        if (p == 0) begin
          if (!(h0 inside {LEAD_PNG, LEAD_GIF, LEAD_RIFF, MARK_FF})) dec = 1'b1;
        end else if (p == POS_JPEG_SOI && h0 == MARK_FF) begin
          if (sn_hdr[1] != MARK_SOI) begin
            dec = 1'b1;
          end else begin
            sn_mode = SNIFF_JPEG;
            sn_skip = '0;
          end
        end else if (p == POS_GIF_DONE && h0 == LEAD_GIF) begin
          dec = 1'b1;
          if ({hdr_be32(0), sn_hdr[4], sn_hdr[5]} inside {SIG_GIF87, SIG_GIF89}) begin
            df = 1'b1;
            dw = {16'd0, sn_hdr[7], sn_hdr[6]};
            dh = {16'd0, sn_hdr[9], sn_hdr[8]};
          end
        end else if (p == POS_WEBP_TAG && h0 == LEAD_RIFF) begin
          if (hdr_be32(0) != SIG_RIFF || hdr_be32(8) != SIG_WEBP ||
              !(tag inside {TAG_VP8, TAG_VP8L, TAG_VP8X})) dec = 1'b1;
        end else if (p == POS_PNG_DONE && h0 == LEAD_PNG) begin
          dec = 1'b1;
          if ({hdr_be32(0), hdr_be32(4)} == SIG_PNG) begin
            df = 1'b1;
            dw = hdr_be32(16);
            dh = hdr_be32(20);
          end
        end else if (p == POS_WEBP_DONE && h0 == LEAD_RIFF) begin
          dec = 1'b1;
          df  = 1'b1;
          case (tag)
            TAG_VP8: begin
              dw = {18'd0, sn_hdr[27][5:0], sn_hdr[26]};
              dh = {18'd0, sn_hdr[29][5:0], sn_hdr[28]};
            end
            TAG_VP8L: begin
              v  = {sn_hdr[24], sn_hdr[23], sn_hdr[22], sn_hdr[21]};
              dw = {18'd0, v[13:0]} + 32'd1;
              dh = {18'd0, v[27:14]} + 32'd1;
            end
            TAG_VP8X: begin
              dw = {8'd0, sn_hdr[26], sn_hdr[25], sn_hdr[24]} + 32'd1;
              dh = {8'd0, sn_hdr[29], sn_hdr[28], sn_hdr[27]} + 32'd1;
            end
            default: df = 1'b0;
          endcase
        end
      end else if (sn_mode == SNIFF_JPEG && p >= POS_JPEG_WALK) begin
        // Marker walk over the oldest window byte
        m = sn_win[1];
        if (sn_skip != 0) begin
          sn_skip = sn_skip - 17'd1;
        end else if (sn_win[0] != MARK_FF || m == MARK_FF) begin
          // plain byte or fill byte: step by one
        end else if (m == MARK_SOI || m == MARK_TEM || (m >= MARK_RST0 && m <= MARK_RST7)) begin
          sn_skip = 17'd1;
        end else if (m >= MARK_SOF_LO && m <= MARK_SOF_HI &&
                     !(m inside {MARK_DHT, MARK_JPG, MARK_DAC})) begin
          dec = 1'b1;
          df  = 1'b1;
          dw  = {16'd0, sn_win[7], sn_win[8]};
          dh  = {16'd0, sn_win[5], sn_win[6]};
        end else begin
          len = {sn_win[2], sn_win[3]};
          if (len < 16'd2) dec = 1'b1;
          else sn_skip = {1'b0, len} + 17'd1;
        end
      end
      if (dec) begin
        got     = 1'b1;
        r       = '{found: df, width: dw, height: dh};
        sn_done = 1'b1;
        sn_mode = SNIFF_DONE;
      end
    end

    // End of file: undecided files report zeros
    if (last) begin
      if (!sn_done) begin
        got = 1'b1;
        r   = '0;
      end
      sniff_clear();
    end else if (sn_pos != POS_MAX) begin
      sn_pos = sn_pos + 6'd1;
    end
  endtask

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(3))
      0:       return 32'h0;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // One JPEG piece ahead of the frame header
  task automatic jpeg_piece(input int sel);
    logic [7:0]  mk;
    logic [7:0]  b;
    logic [15:0] len;
    case (sel)
      0: file_q.push_back(MARK_FF);  // fill byte
      1: begin
        file_q.push_back(MARK_FF);
        file_q.push_back(MARK_RST0 + 8'($urandom_range(7)));
      end
      2: begin
        file_q.push_back(MARK_FF);
        file_q.push_back(MARK_TEM);
      end
      3: begin
        file_q.push_back(MARK_FF);
        file_q.push_back(MARK_SOI);
      end
      4: begin
        case ($urandom_range(4))
          0:       mk = MARK_APP0 + 8'($urandom_range(15));
          1:       mk = MARK_DHT;
          2:       mk = MARK_JPG;
          3:       mk = MARK_DAC;
          default: mk = MARK_COM;
        endcase
        len = ($urandom_range(99) < 3) ? 16'($urandom_range(600, 200))
                                       : 16'($urandom_range(20, 2));
        file_q.push_back(MARK_FF);
        file_q.push_back(mk);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        repeat (int'(len) - 2) file_q.push_back(8'($urandom));
      end
      default: begin
        b = 8'($urandom_range(254));  // any byte but a marker lead
        file_q.push_back(b);
      end
    endcase
  endtask

  // Build one file into file_q
  task automatic make_file(input file_kind_e kind, input logic [31:0] w, input logic [31:0] h,
                           input logic [15:0] extra);
    logic [47:0] gsig;
    logic [31:0] wsig;
    logic [31:0] tag;
    logic [7:0]  b;
    logic [7:0]  mk;
    int          k;
    file_q.delete();
    case (kind)
      F_RAW: begin
        file_q.push_back(w[7:0]);
      end
      F_PNG, F_PNG_BADSIG: begin
        for (k = 0; k < 8; k++) file_q.push_back(SIG_PNG[63-8*k -: 8]);
        if (kind == F_PNG_BADSIG) file_q[3] = file_q[3] ^ 8'h20;
        for (k = 0; k < 4; k++) file_q.push_back(IHDR_LEN[31-8*k -: 8]);
        for (k = 0; k < 4; k++) file_q.push_back(CHUNK_IHDR[31-8*k -: 8]);
        for (k = 0; k < 4; k++) file_q.push_back(w[31-8*k -: 8]);
        for (k = 0; k < 4; k++) file_q.push_back(h[31-8*k -: 8]);
      end
      F_GIF87, F_GIF89, F_GIF_BAD: begin
        gsig = (kind == F_GIF87) ? SIG_GIF87 :
               (kind == F_GIF89) ? SIG_GIF89 : (SIG_GIF89 ^ 48'h000000000100);
        for (k = 0; k < 6; k++) file_q.push_back(gsig[47-8*k -: 8]);
        file_q.push_back(w[7:0]);
        file_q.push_back(w[15:8]);
        file_q.push_back(h[7:0]);
        file_q.push_back(h[15:8]);
      end
      F_VP8, F_VP8L, F_VP8X, F_WEBP_BADTAG, F_RIFF_NOWEBP: begin
        wsig = (kind == F_RIFF_NOWEBP) ? (SIG_WEBP ^ 32'h1) : SIG_WEBP;
        tag  = (kind == F_VP8L) ? TAG_VP8L :
               (kind == F_VP8X) ? TAG_VP8X :
               (kind == F_WEBP_BADTAG) ? (TAG_VP8X ^ 32'h1) : TAG_VP8;
        for (k = 0; k < 4; k++) file_q.push_back(SIG_RIFF[31-8*k -: 8]);
        repeat (4) file_q.push_back(8'($urandom));
        for (k = 0; k < 4; k++) file_q.push_back(wsig[31-8*k -: 8]);
        for (k = 0; k < 4; k++) file_q.push_back(tag[31-8*k -: 8]);
        repeat (14) file_q.push_back(8'($urandom));
        if (kind == F_VP8L) begin
          for (k = 0; k < 4; k++) file_q[21+k] = w[8*k +: 8];
        end else if (kind == F_VP8X) begin
          for (k = 0; k < 3; k++) file_q[24+k] = w[8*k +: 8];
          for (k = 0; k < 3; k++) file_q[27+k] = h[8*k +: 8];
        end else begin
          file_q[26] = w[7:0];
          file_q[27] = w[15:8];
          file_q[28] = h[7:0];
          file_q[29] = h[15:8];
        end
      end
      F_JPEG_BADSOI: begin
        b = 8'($urandom);
        if (b == MARK_SOI) b = ~b;
        file_q.push_back(MARK_FF);
        file_q.push_back(b);
      end
      default: begin
        file_q.push_back(MARK_FF);
        file_q.push_back(MARK_SOI);
        case (kind)
          F_JPEG, F_JPEG_TRUNC: repeat ($urandom_range(5)) jpeg_piece($urandom_range(5));
          F_JPEG_ALL: repeat (2) for (k = 0; k < 6; k++) jpeg_piece(k);
          F_JPEG_BADLEN: begin
            file_q.push_back(MARK_FF);
            file_q.push_back(MARK_APP0);
            file_q.push_back(8'h00);
            file_q.push_back(8'($urandom_range(1)));
            repeat (10) file_q.push_back(8'($urandom));
          end
          default: begin
            // long segment; extra carries its length
            file_q.push_back(MARK_FF);
            file_q.push_back(MARK_APP0 + 8'd1);
            file_q.push_back(extra[15:8]);
            file_q.push_back(extra[7:0]);
            repeat (int'(extra) - 2) file_q.push_back(8'($urandom));
          end
        endcase
        if (kind inside {F_JPEG, F_JPEG_ALL, F_JPEG_LONG}) begin
          do mk = MARK_SOF_LO + 8'($urandom_range(15));
          while (mk inside {MARK_DHT, MARK_JPG, MARK_DAC});
          file_q.push_back(MARK_FF);
          file_q.push_back(mk);
          file_q.push_back(SOF_LEN[15:8]);
          file_q.push_back(SOF_LEN[7:0]);
          file_q.push_back(8'd8);
          file_q.push_back(h[15:8]);
          file_q.push_back(h[7:0]);
          file_q.push_back(w[15:8]);
          file_q.push_back(w[7:0]);
          repeat (3) file_q.push_back(8'($urandom));
        end
      end
    endcase
    if (kind != F_JPEG_LONG) repeat (extra) file_q.push_back(8'($urandom));
  endtask

  // Drive one byte beat and predict its result once accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit      got;
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    byte_cnt++;
    sniff_byte(b, last, got, r);
    if (got) dims_q.push_back(cur_fixed ? cur_want : r);
  endtask

  task automatic send_file(input logic fixed, input result_t want);
    int i;
    cur_fixed = fixed;
    cur_want  = want;
    file_cnt++;
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // Hold the sender off until every expected result is out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk);
    while (dims_q.size() != 0);
  endtask

  // Random files, mostly well-formed, some broken or noise
  task automatic run_random(input int sidle, input int ridle);
    int         b0;
    int         f0;
    int         n;
    file_kind_e kind;
    drain_results();
    send_idle = sidle;
    recv_idle = ridle;
    b0 = byte_cnt;
    f0 = file_cnt;
    while (byte_cnt - b0 < 40 || file_cnt - f0 < 2) begin
      n = $urandom_range(99);
      if (n < 70) begin
        case ($urandom_range(7))
          0: kind = F_PNG;
          1: kind = F_GIF87;
          2: kind = F_GIF89;
          3: kind = F_VP8;
          4: kind = F_VP8L;
          5: kind = F_VP8X;
          6: kind = F_JPEG;
          default: kind = F_JPEG_ALL;
        endcase
      end else if (n < 85) begin
        case ($urandom_range(6))
          0: kind = F_PNG_BADSIG;
          1: kind = F_GIF_BAD;
          2: kind = F_WEBP_BADTAG;
          3: kind = F_RIFF_NOWEBP;
          4: kind = F_JPEG_BADLEN;
          5: kind = F_JPEG_BADSOI;
          default: kind = F_JPEG_TRUNC;
        endcase
      end else begin
        kind = F_RAW;
      end
      make_file(kind, rand_dim(), rand_dim(),
                16'((kind == F_RAW) ? $urandom_range(40) : $urandom_range(6)));
      // a flipped header bit or an early end now and then
      if ($urandom_range(99) < 12) begin
        n = $urandom_range((file_q.size() < HDR_DEPTH) ? file_q.size() - 1 : HDR_DEPTH - 1);
        file_q[n] = file_q[n] ^ (8'h01 << $urandom_range(7));
      end
      if ($urandom_range(99) < 10) begin
        n = $urandom_range(file_q.size(), 1);
        while (file_q.size() > n) void'(file_q.pop_back());
      end
      send_file(1'b0, '0);
      if ($urandom_range(99) < 4) drain_results();
    end
  endtask

  // Stimulus
  initial begin
    int n;
    sniff_clear();
    dir_tab = '{
      '{F_RAW,         32'h00,       32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_RAW,         32'h89,       32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_GIF87,       32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b1, 32'h0, 32'h0}},
      '{F_GIF89,       32'hFFFF,     32'hFFFF,     16'd0,     16'd0,  1'b1,
        '{1'b1, 32'hFFFF, 32'hFFFF}},
      '{F_PNG,         32'hFFFFFFFF, 32'h0,        16'd0,     16'd0,  1'b1,
        '{1'b1, 32'hFFFFFFFF, 32'h0}},
      '{F_PNG,         32'h12345678, 32'h9ABCDEF0, 16'd5,     16'd0,  1'b1,
        '{1'b1, 32'h12345678, 32'h9ABCDEF0}},
      '{F_VP8,         32'hFFFF,     32'hFFFF,     16'd0,     16'd0,  1'b0, '0},
      '{F_VP8L,        32'hFFFFFFFF, 32'h0,        16'd0,     16'd0,  1'b0, '0},
      '{F_VP8X,        32'hFFFFFF,   32'h0,        16'd0,     16'd0,  1'b0, '0},
      '{F_VP8,         32'h0,        32'h0,        16'd3,     16'd0,  1'b0, '0},
      '{F_WEBP_BADTAG, 32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_RIFF_NOWEBP, 32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_PNG_BADSIG,  32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_GIF_BAD,     32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_JPEG_BADSOI, 32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_JPEG,        32'h0280,     32'h01E0,     16'd2,     16'd0,  1'b0, '0},
      '{F_JPEG_ALL,    32'hFFFF,     32'h0,        16'd0,     16'd0,  1'b0, '0},
      '{F_JPEG_BADLEN, 32'h0,        32'h0,        16'd0,     16'd0,  1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_JPEG_TRUNC,  32'h0,        32'h0,        16'd0,     16'd0,  1'b0, '0},
      '{F_JPEG_LONG,   32'h1,        32'h1,        16'd40,    16'd0,  1'b0, '0},
      '{F_PNG,         32'h55,       32'hAA,       16'd0,     16'd20, 1'b1, '{1'b0, 32'h0, 32'h0}},
      '{F_RAW,         32'h52,       32'h0,        16'd5,     16'd0,  1'b0, '0},
      '{F_GIF89,       32'h1234,     32'h5678,     16'd8,     16'd0,  1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed files
    send_idle = 6;
    recv_idle = 45;
    for (n = 0; n < NDIR; n++) begin
      make_file(dir_tab[n].kind, dir_tab[n].w, dir_tab[n].h, dir_tab[n].extra);
      if (dir_tab[n].cut != 0)
        while (file_q.size() > dir_tab[n].cut) void'(file_q.pop_back());
      send_file(dir_tab[n].fixed, dir_tab[n].want);
    end

    // Random files under three idling patterns
    run_random(6, 45);
    run_random(45, 6);
    run_random(0, 0);

    in_tvalid <= 1'b0;
    while (dims_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d files in %0d byte beats, %0d result beats checked.",
             file_cnt, byte_cnt, dims_seen);
    $display("Covered PNG, GIF, WebP chunk forms and JPEG marker walks, sound and broken.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/hidsn_pkg.sv
hdl/hidsn_in_reg.sv
hdl/hidsn_parse.sv
hdl/hidsn_out_reg.sv
hdl/image_header_dimension_sniffer_unit.sv
tb/tb.sv
